// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ===== hdl/ata_pkg.sv =====
// Package: widths, command codes, queue entry type and a helper function.
`default_nettype none
package ata_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned TrigIterDef = 16;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned DataW       = 32;
  localparam int unsigned IdxW        = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_IDENT  = 3'd0,
    CMD_TRANS  = 3'd1,
    CMD_SCALE  = 3'd2,
    CMD_ROTATE = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_MULT   = 3'd5,
    CMD_READ   = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_e;

  // Decoded word handed from the front to the back
  typedef struct packed {
    cmd_e              cmd;
    logic [DataW-1:0]  v1;
    logic [DataW-1:0]  v2;
    logic [IdxW-1:0]   idx;
  } job_t;

  // Diagonal element test for a column-major 4x4 index
  function automatic logic is_diag(input logic [IdxW-1:0] i);
    return (i[1:0] == i[3:2]);
  endfunction
endpackage
`default_nettype wire

// ===== hdl/ata_if.sv =====
// Valid/ready channel interfaces for command and result words.
`default_nettype none
interface ata_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                command;
  logic signed [31:0]        first_value;
  logic signed [31:0]        second_value;
  logic [3:0]                element_index;
  modport source (output valid, command, first_value, second_value, element_index,
                  input ready);
  modport sink   (input valid, command, first_value, second_value, element_index,
                  output ready);
endinterface

interface ata_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               overflow;
  modport source (output valid, read_value, overflow, input ready);
  modport sink   (input valid, read_value, overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/ata_front.sv =====
// Front end: takes command words and queues them for the back end.
`default_nettype none
module ata_front import ata_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ata_cmd_if.sink   cmd_i,
  output job_t      job_o,
  output logic      job_valid_o,
  input  wire logic job_ready_i
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             push, pop;

  assign cmd_i.ready = (cnt_q != (PtrW+1)'(Depth));
  assign push = cmd_i.valid && cmd_i.ready;
  assign job_valid_o = (cnt_q != '0);
  assign pop = job_valid_o && job_ready_i;
  assign job_o = mem_q[rd_q];

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{cmd: cmd_e'(cmd_i.command), v1: cmd_i.first_value,
                      v2: cmd_i.second_value, idx: cmd_i.element_index};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_cnt_bound, cnt_q <= (PtrW+1)'(Depth), "queue count beyond depth")
  `ASSERT_CLK(a_cnt_step, (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1, "count slip")
endmodule
`default_nettype wire

// ===== hdl/ata_trig.sv =====
// Sine/cosine unit: angle reduction and an iterative Taylor series in Q30.
`default_nettype none
module ata_trig import ata_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef,
  parameter int unsigned TrigIter = TrigIterDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DataW-1:0]  angle_i,
  output logic                   done_o,
  output logic [DataW-1:0]       sin_o,
  output logic [DataW-1:0]       cos_o
);
  localparam logic [63:0] Full    = 64'(360) << FracBits;
  localparam logic [63:0] Quarter = 64'(90) << FracBits;
  localparam logic [26:0] Pi180   = 27'd74961321;
  localparam int unsigned KW      = $clog2(TrigIter + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_MOD = 4'd1, S_QUAD = 4'd2, S_RAD = 4'd3,
                         S_X2 = 4'd4, S_ACC = 4'd5, S_MS = 4'd6, S_MC = 4'd7,
                         S_DIV = 4'd8, S_OUT = 4'd9;

  logic [3:0]         st_q;
  logic [KW-1:0]      k_q;
  logic signed [40:0] a_q;      // reducing angle
  logic [1:0]         quad_q;
  logic [31:0]        x_q, x2_q, ts_q, tc_q;
  logic signed [36:0] as_q, ac_q;
  logic [63:0]        prod_q;
  logic [31:0]        num_q;
  logic [11:0]        den_q;
  logic [31:0]        quo_q;
  logic [42:0]        rem_q;
  logic [5:0]         bit_q;
  logic               dsel_q;   // 0: sine term, 1: cosine term
  logic [DataW-1:0]   s_rnd, c_rnd;
  logic [58:0]        rsum;
  logic [11:0]        dens, denc;

  // Round Q30 to the output format, negative clamps to zero
  function automatic logic [DataW-1:0] q30r(input logic signed [36:0] v);
    logic [37:0] t;
    if (v < 0) return '0;
    t = 38'(v) + (38'(1) << (29 - FracBits));
    return DataW'(t >> (30 - FracBits));
  endfunction

  assign s_rnd = q30r(as_q);
  assign c_rnd = q30r(ac_q);
  assign dens  = 12'((2*k_q+2)*(2*k_q+3));
  assign denc  = 12'((2*k_q+1)*(2*k_q+2));
  assign rsum  = 59'(a_q[31:0]) * 59'(Pi180);
  assign done_o = (st_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      k_q  <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: if (start_i) begin
          a_q  <= 41'(signed'(angle_i));
          st_q <= S_MOD;
        end
        // Bring angle into [0, 360) by repeated steps of 360 scaled
        S_MOD: begin
          if (a_q < 0) a_q <= a_q + 41'(Full);
          else if (a_q >= 41'(Full)) a_q <= a_q - 41'(Full);
          else begin
            quad_q <= '0;
            st_q   <= S_QUAD;
          end
        end
        S_QUAD: begin
          if (a_q >= 41'(Quarter)) begin
            a_q    <= a_q - 41'(Quarter);
            quad_q <= quad_q + 1'b1;
          end else st_q <= S_RAD;
        end
        S_RAD: begin
          x_q  <= 32'((60'(rsum) + (60'(1) << (FracBits + 1))) >> (FracBits + 2));
          st_q <= S_X2;
        end
        S_X2: begin
          x2_q <= 32'((64'(x_q) * 64'(x_q)) >> 30);
          ts_q <= x_q;
          tc_q <= 32'h4000_0000;
          as_q <= '0; ac_q <= '0; k_q <= '0;
          st_q <= S_ACC;
        end
        S_ACC: begin
          if (k_q[0]) begin
            as_q <= as_q - 37'(ts_q); ac_q <= ac_q - 37'(tc_q);
          end else begin
            as_q <= as_q + 37'(ts_q); ac_q <= ac_q + 37'(tc_q);
          end
          st_q <= S_MS;
        end
        S_MS: begin
          prod_q <= 64'(ts_q) * 64'(x2_q);
          st_q   <= S_DIV;
          dsel_q <= 1'b0;
          num_q  <= '0;
          bit_q  <= 6'd0;
        end
        S_MC: begin
          prod_q <= 64'(tc_q) * 64'(x2_q);
          st_q   <= S_DIV;
          dsel_q <= 1'b1;
          bit_q  <= 6'd0;
        end
        // Restoring divide, one quotient bit a cycle
        S_DIV: begin
          if (bit_q == 6'd0) begin
            rem_q <= '0;
            quo_q <= '0;
            num_q <= 32'(prod_q >> 30);
            den_q <= dsel_q ? denc : dens;
            bit_q <= 6'd32;
          end else begin
            logic [42:0] r;
            r = {rem_q[41:0], num_q[31]};
            num_q <= {num_q[30:0], 1'b0};
            if (r >= 43'(den_q)) begin
              rem_q <= r - 43'(den_q); quo_q <= {quo_q[30:0], 1'b1};
            end else begin
              rem_q <= r; quo_q <= {quo_q[30:0], 1'b0};
            end
            bit_q <= bit_q - 1'b1;
            if (bit_q == 6'd1) begin
              if (!dsel_q) begin
                ts_q <= (r >= 43'(den_q)) ? {quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};
                st_q <= S_MC;
              end else begin
                tc_q <= (r >= 43'(den_q)) ? {quo_q[30:0], 1'b1} : {quo_q[30:0], 1'b0};
                k_q  <= k_q + 1'b1;
                st_q <= (k_q == KW'(TrigIter - 1)) ? S_OUT : S_ACC;
              end
            end
          end
        end
        S_OUT: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Quadrant swap and sign
  always_comb begin
    unique case (quad_q)
      2'd0: begin sin_o = s_rnd;   cos_o = c_rnd;   end
      2'd1: begin sin_o = c_rnd;   cos_o = -s_rnd;  end
      2'd2: begin sin_o = -s_rnd;  cos_o = -c_rnd;  end
      default: begin sin_o = -c_rnd; cos_o = s_rnd; end
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/ata_back.sv =====
// Back end: matrix store, multiply-accumulate sequencer and result register.
`default_nettype none
module ata_back import ata_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef,
  parameter int unsigned TrigIter = TrigIterDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  job_t      job_i,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  ata_res_if.source res_o
);
  localparam logic [DataW-1:0] One = DataW'(1) << FracBits;
  localparam logic [2:0] B_IDLE = 3'd0, B_TRIG = 3'd1, B_MAC = 3'd2, B_ACC = 3'd3,
                         B_COPY = 3'd4, B_DONE = 3'd5;

  logic [2:0]        st_q;
  job_t              job_q;
  logic [DataW-1:0]  cur_q [16];
  logic [DataW-1:0]  opm_q [16];
  logic [DataW-1:0]  res_q [16];
  logic [DataW-1:0]  sin_q, cos_q;
  logic [3:0]        el_q;      // element being built
  logic [1:0]        k_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] sum_q;
  logic              ovf_q;
  logic              rvalid_q;
  logic [DataW-1:0]  rdata_q;
  logic              rovf_q;
  logic              trig_done;
  logic [DataW-1:0]  tsin, tcos;
  logic [DataW-1:0]  a_el, b_el;
  logic signed [63:0] rp, nsum;
  logic [3:0]        bidx;

  ata_trig #(.FracBits(FracBits), .TrigIter(TrigIter)) u_trig (
    .clk_i, .rst_ni,
    .start_i(st_q == B_IDLE && job_valid_i && !rvalid_q && job_i.cmd == CMD_ROTATE),
    .angle_i(job_i.v1), .done_o(trig_done), .sin_o(tsin), .cos_o(tcos)
  );

  // Right-hand operand element: the queued transform or the operand matrix
  always_comb begin
    bidx = {el_q[3:2], k_q};
    b_el = is_diag(bidx) ? One : '0;
    unique case (job_q.cmd)
      CMD_TRANS: begin
        if (bidx == 4'd12) b_el = job_q.v1;
        if (bidx == 4'd13) b_el = job_q.v2;
      end
      CMD_SCALE: begin
        if (bidx == 4'd0) b_el = job_q.v1;
        if (bidx == 4'd5) b_el = job_q.v2;
      end
      CMD_ROTATE: begin
        if (bidx == 4'd0 || bidx == 4'd5) b_el = cos_q;
        if (bidx == 4'd1) b_el = sin_q;
        if (bidx == 4'd4) b_el = -sin_q;
      end
      CMD_MULT: b_el = opm_q[bidx];
      default: ;
    endcase
    a_el = cur_q[{k_q, el_q[1:0]}];
    rp   = (prod_q + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    nsum = sum_q + rp;
  end

  assign job_ready_o = (st_q == B_IDLE) && !rvalid_q;
  assign res_o.valid = rvalid_q;
  assign res_o.read_value = rdata_q;
  assign res_o.overflow = rovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      rvalid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        cur_q[i] <= is_diag(4'(i)) ? One : '0;
        opm_q[i] <= is_diag(4'(i)) ? One : '0;
      end
    end else begin
      if (rvalid_q && res_o.ready) rvalid_q <= 1'b0;
      unique case (st_q)
        B_IDLE: if (job_valid_i && !rvalid_q) begin
          job_q <= job_i;
          el_q <= '0; k_q <= '0; sum_q <= '0; ovf_q <= 1'b0;
          rdata_q <= '0; rovf_q <= 1'b0;
          unique case (job_i.cmd)
            CMD_IDENT: begin
              for (int i = 0; i < 16; i++) cur_q[i] <= is_diag(4'(i)) ? One : '0;
              rvalid_q <= 1'b1;
            end
            CMD_WRITE: begin opm_q[job_i.idx] <= job_i.v1; rvalid_q <= 1'b1; end
            CMD_READ:  begin rdata_q <= cur_q[job_i.idx]; rvalid_q <= 1'b1; end
            CMD_ROTATE: st_q <= B_TRIG;
            CMD_TRANS, CMD_SCALE, CMD_MULT: st_q <= B_MAC;
            default: rvalid_q <= 1'b1;
          endcase
        end
        B_TRIG: if (trig_done) begin
          sin_q <= tsin; cos_q <= tcos; st_q <= B_MAC;
        end
        // One product, accumulated in B_ACC before the next product is formed
        B_MAC: begin
          prod_q <= $signed(a_el) * $signed(b_el);
          st_q <= B_ACC;
        end
        B_ACC: begin
          if (k_q == 2'd3) begin
            if (nsum > 64'sd2147483647) begin
              res_q[el_q] <= 32'h7FFF_FFFF; ovf_q <= 1'b1;
            end else if (nsum < -64'sd2147483648) begin
              res_q[el_q] <= 32'h8000_0000; ovf_q <= 1'b1;
            end else res_q[el_q] <= nsum[31:0];
            sum_q <= '0;
            el_q <= el_q + 1'b1;
            st_q <= (el_q == 4'd15) ? B_COPY : B_MAC;
          end else begin
            sum_q <= nsum;
            st_q <= B_MAC;
          end
          k_q <= k_q + 1'b1;
        end
        B_COPY: begin
          for (int i = 0; i < 16; i++) cur_q[i] <= res_q[i];
          rovf_q <= ovf_q; rvalid_q <= 1'b1; st_q <= B_IDLE;
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_busy_no_res, (st_q != B_IDLE) |-> !rvalid_q, "result while busy")
  `ASSERT_CLK(a_hold, (rvalid_q && !res_o.ready) |=> rvalid_q && $stable(rdata_q),
              "result dropped")
  `ASSERT_CLK(a_ovf_read, rvalid_q && job_q.cmd == CMD_READ |-> !rovf_q, "read overflow")
endmodule
`default_nettype wire

// ===== hdl/affine_transform_accumulator_4x4.sv =====
// Top level of the 4x4 fixed-point transform accumulator.
`default_nettype none
// Keeps a column-major 4x4 Q16.16 matrix, identity after reset, and post-multiplies
// it by each transform command; every command returns one result word. Identity,
// operand write, read and the unused code need no engine pass: the back end registers
// their result word as it takes them from the queue. Translate, scale and operand
// multiply form 64 products through one shared multiplier, each product registered
// and then accumulated, plus a copy. Rotate adds angle reduction and a Taylor series
// of TrigIter terms, each using the one-bit restoring divider (two 32-bit divides a
// term). A two-word queue sits between the command port and the engine.
module affine_transform_accumulator_4x4 import ata_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef,
  parameter int unsigned TrigIter = TrigIterDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ata_cmd_if.sink   cmd_i,
  ata_res_if.source res_o
);
  job_t job;
  logic job_valid, job_ready;

  ata_front #(.Depth(2)) u_front (
    .clk_i, .rst_ni, .cmd_i, .job_o(job), .job_valid_o(job_valid), .job_ready_i(job_ready)
  );

  ata_back #(.FracBits(FracBits), .TrigIter(TrigIter)) u_back (
    .clk_i, .rst_ni, .job_i(job), .job_valid_i(job_valid), .job_ready_o(job_ready), .res_o
  );
endmodule
`default_nettype wire

// ===== verif/affine_transform_accumulator_4x4_test.sv =====
// Self-checking testbench for the 4x4 fixed-point transform accumulator.
`default_nettype none
module affine_transform_accumulator_4x4_test;
  import ata_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Frac     = FracBitsDef;
  localparam int unsigned TrigN    = TrigIterDef;
  localparam int unsigned StallMax = 20000;
  localparam longint unsigned PiOver180Q32 = 64'd74961321;
  localparam int One = 1 << Frac;

  typedef struct {
    logic signed [31:0] read_value;
    logic               overflow;
  } outcome_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ata_cmd_if cmd_if();
  ata_res_if res_if();

  affine_transform_accumulator_4x4 dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  always #2 clk_i = ~clk_i;

  // Shadow state of the block
  int       xform[16];
  int       opnd[16];
  outcome_t pending_q[$];
  int       n_errors = 0;
  bit       idle_on = 1'b1;
  int       stall_left = 0;
  int       quiet_cycles = 0;

  function automatic void set_identity(ref int m[16]);
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? One : 0;
  endfunction

  // xform := xform * t, rounded products, saturated sums
  function automatic bit post_mult(input int t[16]);
    int     res[16];
    bit     ovf;
    longint sum, p;
    ovf = 1'b0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sum = 0;
        for (int k = 0; k < 4; k++) begin
          p = longint'(xform[k*4+r]) * longint'(t[c*4+k]);
          sum += (p + (longint'(1) << (Frac-1))) >>> Frac;
        end
        if (sum > 64'sd2147483647) begin
          sum = 64'sd2147483647; ovf = 1'b1;
        end
        if (sum < -64'sd2147483648) begin
          sum = -64'sd2147483648; ovf = 1'b1;
        end
        res[c*4+r] = int'(sum);
      end
    end
    xform = res;
    return ovf;
  endfunction

  function automatic int q30_round(input longint v);
    if (v < 0) v = 0;
    return int'((v + (longint'(1) << (29 - Frac))) >>> (30 - Frac));
  endfunction

  // Sine and cosine of an angle in degrees, fixed point
  function automatic void trig_terms(input int angle, output int sn, output int cs);
    longint full, quarter, a, q, r;
    longint unsigned rad, x2, ts, tc;
    longint as_acc, ac_acc;
    int s, c;
    full    = longint'(360) << Frac;
    quarter = longint'(90) << Frac;
    a = longint'(angle) % full;
    if (a < 0) a += full;
    q = a / quarter;
    r = a - q * quarter;
    rad = (longint'(r) * PiOver180Q32 + (64'd1 << (Frac + 1))) >> (Frac + 2);
    x2 = (rad * rad) >> 30;
    ts = rad;
    tc = 64'd1 << 30;
    as_acc = 0;
    ac_acc = 0;
    for (longint unsigned k = 0; k < TrigN; k++) begin
      if (k[0]) begin
        as_acc -= longint'(ts); ac_acc -= longint'(tc);
      end else begin
        as_acc += longint'(ts); ac_acc += longint'(tc);
      end
      ts = ((ts * x2) >> 30) / ((2*k + 2) * (2*k + 3));
      tc = ((tc * x2) >> 30) / ((2*k + 1) * (2*k + 2));
    end
    s = q30_round(as_acc);
    c = q30_round(ac_acc);
    case (q)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // Expected result word for one accepted command
  function automatic outcome_t apply_command(input cmd_e op, input int v1, input int v2,
                                             input logic [3:0] idx);
    outcome_t o;
    int t[16];
    int s, c;
    o.read_value = '0;
    o.overflow   = 1'b0;
    set_identity(t);
    case (op)
      CMD_IDENT: set_identity(xform);
      CMD_TRANS: begin
        t[12] = v1; t[13] = v2;
        o.overflow = post_mult(t);
      end
      CMD_SCALE: begin
        t[0] = v1; t[5] = v2;
        o.overflow = post_mult(t);
      end
      CMD_ROTATE: begin
        trig_terms(v1, s, c);
        t[0] = c; t[1] = s; t[4] = -s; t[5] = c;
        o.overflow = post_mult(t);
      end
      CMD_WRITE: opnd[idx] = v1;
      CMD_MULT:  o.overflow = post_mult(opnd);
      CMD_READ:  o.read_value = xform[idx];
      default: ;
    endcase
    return o;
  endfunction

  // Send one command word, with an optional random gap first
  task automatic send_word(input cmd_e op, input int v1, input int v2, input logic [3:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= op;
    cmd_if.first_value   <= v1;
    cmd_if.second_value  <= v2;
    cmd_if.element_index <= idx;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_q.push_back(apply_command(op, v1, v2, idx));
  endtask

  // Result side: random back-pressure bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 7);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result word: read_value=%0d overflow=%0b",
                                     res_if.read_value, res_if.overflow);
      end else begin
        want = pending_q.pop_front();
        if (res_if.read_value !== want.read_value || res_if.overflow !== want.overflow) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: read_value exp %0d got %0d, overflow exp %0b got %0b",
                     want.read_value, res_if.read_value, want.overflow, res_if.overflow);
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallMax) begin
      $display("affine_transform_accumulator_4x4_test failed");
      $finish;
    end
  end

  function automatic int rand_q16();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 4 * One)) - 2 * One;
      2: return One + $signed($urandom_range(0, One)) - One / 2;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  // Extremes, every command, rotation quadrants and the unused code
  task automatic test_directed();
    send_word(CMD_READ, 0, 0, 4'd0);
    send_word(CMD_READ, 0, 0, 4'd15);
    send_word(CMD_WRITE, 32'h7fffffff, 0, 4'd0);
    send_word(CMD_WRITE, 32'h80000000, 0, 4'd15);
    send_word(CMD_MULT, 0, 0, 4'd0);
    send_word(CMD_READ, 0, 0, 4'd0);
    send_word(CMD_IDENT, 0, 0, 4'd0);
    send_word(CMD_TRANS, 32'h7fffffff, 32'h80000000, 4'd0);
    send_word(CMD_SCALE, 32'h7fffffff, 32'h7fffffff, 4'd0);
    send_word(CMD_READ, 0, 0, 4'd12);
    send_word(CMD_IDENT, 0, 0, 4'd0);
    send_word(CMD_ROTATE, 0, 0, 4'd0);
    send_word(CMD_ROTATE, 90 * One, 0, 4'd0);
    send_word(CMD_ROTATE, 180 * One, 0, 4'd0);
    send_word(CMD_ROTATE, -90 * One, 0, 4'd0);
    send_word(CMD_ROTATE, 360 * One - 1, 0, 4'd0);
    send_word(CMD_ROTATE, 32'h7fffffff, 0, 4'd0);
    send_word(CMD_ROTATE, 32'h80000000, 0, 4'd0);
    send_word(CMD_READ, 0, 0, 4'd1);
    send_word(CMD_NOP, 32'hffffffff, 32'hffffffff, 4'd15);
    send_word(CMD_WRITE, One, 0, 4'd15);
    send_word(CMD_WRITE, -One, 0, 4'd0);
    send_word(CMD_IDENT, 0, 0, 4'd0);
  endtask

  // Random command mix; rotates kept rare as they are slow
  task automatic test_random(input int n);
    int   pick;
    cmd_e op;
    for (int i = 0; i < n; i++) begin
      if (i == n - 200) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 5)       op = CMD_IDENT;
      else if (pick < 20) op = CMD_TRANS;
      else if (pick < 33) op = CMD_SCALE;
      else if (pick < 40) op = CMD_ROTATE;
      else if (pick < 60) op = CMD_WRITE;
      else if (pick < 68) op = CMD_MULT;
      else if (pick < 97) op = CMD_READ;
      else                op = CMD_NOP;
      send_word(op, rand_q16(), rand_q16(), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    cmd_if.valid         <= 1'b0;
    cmd_if.command       <= CMD_NOP;
    cmd_if.first_value   <= '0;
    cmd_if.second_value  <= '0;
    cmd_if.element_index <= '0;
    set_identity(xform);
    set_identity(opnd);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1380);
    cmd_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("affine_transform_accumulator_4x4_test passed");
    end else begin
      $display("affine_transform_accumulator_4x4_test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/ata_pkg.sv
hdl/ata_if.sv
hdl/ata_front.sv
hdl/ata_trig.sv
hdl/ata_back.sv
hdl/affine_transform_accumulator_4x4.sv
verif/affine_transform_accumulator_4x4_test.sv
